>>> hw/rtl/fpce_pkg.sv
// Shared types, character codes and place-value table for the format
// character expander. No dependencies.
`timescale 1ns / 1ps

package fpce_pkg;

    // Character codes
    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_A       = 8'h41;
    localparam logic [7:0] CH_LC_X    = 8'h78;
    localparam logic [7:0] CH_UC_X    = 8'h58;
    localparam logic [7:0] CH_LC_D    = 8'h64;
    localparam logic [7:0] CH_LC_I    = 8'h69;
    localparam logic [7:0] CH_LC_C    = 8'h63;
    localparam logic [7:0] CH_UC_C    = 8'h43;

    // Widths and last digit indexes
    localparam int unsigned PLACE_W  = 14;
    localparam int unsigned REM_W    = 17;
    localparam logic [2:0]  HEX_LAST = 3'd3;
    localparam logic [2:0]  DEC_LAST = 3'd4;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_CALC = 3'b010,
        ST_EMIT = 3'b100
    } t_state;

    // Place value of digit idx, most significant first
    function automatic logic [PLACE_W-1:0] place_value(input logic is_hex,
                                                       input logic [2:0] idx);
        logic [PLACE_W-1:0] p;
        p = '0;
        if (is_hex) begin
            unique case (idx)
                3'd0:    p = 14'd4096;
                3'd1:    p = 14'd256;
                3'd2:    p = 14'd16;
                default: p = 14'd1;
            endcase
        end else begin
            unique case (idx)
                3'd0:    p = 14'd10000;
                3'd1:    p = 14'd1000;
                3'd2:    p = 14'd100;
                3'd3:    p = 14'd10;
                default: p = 14'd1;
            endcase
        end
        return p;
    endfunction

    // ASCII for one digit, uppercase letters above nine
    function automatic logic [7:0] digit_char(input logic [3:0] d);
        logic [7:0] c;
        if (d < 4'd10) c = CH_ZERO + {4'd0, d};
        else           c = CH_A + {4'd0, d} - 8'd10;
        return c;
    endfunction

endpackage

>>> hw/rtl/fpce_if.sv
// Valid/ready channel interfaces for the format character expander.
// Depend on nothing but the clock domain of the user.
`timescale 1ns / 1ps

// Input channel: one format byte and its value per transfer
interface fpce_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  format_char;
    logic [15:0] value;

    modport source (output valid, output format_char, output value, input ready);
    modport sink   (input valid, input format_char, input value, output ready);
endinterface

// Output channel: one character per transfer
interface fpce_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       last;

    modport source (output valid, output out_char, output last, input ready);
    modport sink   (input valid, input out_char, input last, output ready);
endinterface

>>> hw/rtl/format_print_char_expander.sv
// Top level of the format character expander: parser, digit sequencer and
// output register. Depends on fpce_pkg and the channel interfaces in fpce_if.
`timescale 1ns / 1ps

// Channel   Dir  Modport  Payload                      Notes
// i_fmt     in   sink     format_char[7:0] value[15:0] one byte per transfer
// o_chr     out  source   out_char[7:0] last           0..5 transfers per input
//
// A byte that emits nothing is consumed in idle; a plain byte or %c goes
// straight to its output transfer. Each digit takes 4 compare-subtract
// steps on the shared unit plus its output transfer. i_fmt.ready is high
// only while idle.
// Reset clears the sequencer and the pending '%' flag. A stall on o_chr
// holds the digit in the output register and pauses the sequencer.
module format_print_char_expander (
    input  logic          i_clk,
    input  logic          i_rst_n,
    fpce_in_if.sink       i_fmt,
    fpce_out_if.source    o_chr
);

    fpce_pkg::t_state r_state, n_state;
    logic                          r_pending, n_pending;
    logic                          r_hex, n_hex;
    logic [2:0]                    r_idx, n_idx;
    logic [1:0]                    r_step, n_step;
    logic [3:0]                    r_dig, n_dig;
    logic [fpce_pkg::REM_W-1:0]    r_rem, n_rem;
    logic [7:0]                    r_char, n_char;
    logic                          r_last, n_last;

    logic [fpce_pkg::REM_W-1:0]    w_trial;
    logic                          w_ge;
    logic [2:0]                    w_last_idx;
    logic [7:0]                    w_c;

    // Shared compare-subtract unit: place value scaled by 8, 4, 2, 1
    assign w_trial = fpce_pkg::REM_W'(fpce_pkg::place_value(r_hex, r_idx)) << r_step;
    assign w_ge    = (r_rem >= w_trial);
    assign w_last_idx = r_hex ? fpce_pkg::HEX_LAST : fpce_pkg::DEC_LAST;
    assign w_c     = i_fmt.format_char;

    assign i_fmt.ready    = (r_state == fpce_pkg::ST_IDLE);
    assign o_chr.valid    = (r_state == fpce_pkg::ST_EMIT);
    assign o_chr.out_char = r_char;
    assign o_chr.last     = r_last;

    // Sequencer
    always_comb begin
        n_state   = r_state;
        n_pending = r_pending;
        n_hex     = r_hex;
        n_idx     = r_idx;
        n_step    = r_step;
        n_dig     = r_dig;
        n_rem     = r_rem;
        n_char    = r_char;
        n_last    = r_last;
        unique case (r_state)
            fpce_pkg::ST_IDLE: begin
                if (i_fmt.valid) begin
                    n_rem  = {1'b0, i_fmt.value};
                    n_idx  = 3'd0;
                    n_step = 2'd3;
                    n_dig  = 4'd0;
                    priority if (w_c == fpce_pkg::CH_NUL) begin
                        n_pending = 1'b0;
                    end else if (r_pending) begin
                        n_pending = 1'b0;
                        priority if (w_c == fpce_pkg::CH_LC_X || w_c == fpce_pkg::CH_UC_X) begin
                            n_hex   = 1'b1;
                            n_state = fpce_pkg::ST_CALC;
                        end else if (w_c == fpce_pkg::CH_LC_D || w_c == fpce_pkg::CH_LC_I) begin
                            n_hex   = 1'b0;
                            n_state = fpce_pkg::ST_CALC;
                        end else if (w_c == fpce_pkg::CH_LC_C || w_c == fpce_pkg::CH_UC_C) begin
                            n_char  = i_fmt.value[7:0];
                            n_last  = 1'b1;
                            n_state = fpce_pkg::ST_EMIT;
                        end else begin
                            n_state = fpce_pkg::ST_IDLE;
                        end
                    end else if (w_c == fpce_pkg::CH_PERCENT) begin
                        n_pending = 1'b1;
                    end else begin
                        n_char  = w_c;
                        n_last  = 1'b1;
                        n_state = fpce_pkg::ST_EMIT;
                    end
                end
            end
            fpce_pkg::ST_CALC: begin
                // One quotient bit per cycle
                if (w_ge) begin
                    n_rem        = r_rem - w_trial;
                    n_dig[r_step] = 1'b1;
                end
                if (r_step == 2'd0) begin
                    n_char  = fpce_pkg::digit_char(n_dig);
                    n_last  = (r_idx == w_last_idx);
                    n_state = fpce_pkg::ST_EMIT;
                end else begin
                    n_step = r_step - 2'd1;
                end
            end
            fpce_pkg::ST_EMIT: begin
                if (o_chr.ready) begin
                    if (r_last) begin
                        n_state = fpce_pkg::ST_IDLE;
                    end else begin
                        n_idx   = r_idx + 3'd1;
                        n_step  = 2'd3;
                        n_dig   = 4'd0;
                        n_state = fpce_pkg::ST_CALC;
                    end
                end
            end
            default: begin
                n_state = fpce_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= fpce_pkg::ST_IDLE;
            r_pending <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_pending <= n_pending;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_hex  <= n_hex;
        r_idx  <= n_idx;
        r_step <= n_step;
        r_dig  <= n_dig;
        r_rem  <= n_rem;
        r_char <= n_char;
        r_last <= n_last;
    end

endmodule

>>> tb/tb_format_print_char_expander.sv
// Self-checking testbench for format_print_char_expander: drives format bytes
// over fpce_in_if and checks every character on fpce_out_if against a local
// predictor. Depends on fpce_pkg, fpce_if and the block itself.
`timescale 1ns / 1ps

module tb_format_print_char_expander;

    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned RANDOM_ITEMS = 400;
    localparam int unsigned TAIL_ITEMS   = 60;
    localparam int unsigned SETTLE_CYCLES = 40;

    // One predicted output character
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_chr;

    logic i_clk;
    logic i_rst_n;

    fpce_in_if  fmt_if ();
    fpce_out_if chr_if ();

    format_print_char_expander u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fmt   (fmt_if),
        .o_chr   (chr_if)
    );

    t_chr        expected_chars[$];
    bit          spec_armed;
    bit          calm_tail;
    int unsigned mismatch_count;
    int unsigned cycle_count;
    int unsigned sent_items;

    logic [7:0] conv_letters[6] = '{fpce_pkg::CH_LC_X, fpce_pkg::CH_UC_X,
                                    fpce_pkg::CH_LC_D, fpce_pkg::CH_LC_I,
                                    fpce_pkg::CH_LC_C, fpce_pkg::CH_UC_C};

    // Clock, 2 ns period
    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        mismatch_count++;
    endtask

    // ASCII for one digit, uppercase above nine
    function automatic logic [7:0] ascii_digit(input int unsigned d);
        if (d < 10) return fpce_pkg::CH_ZERO + 8'(d);
        return fpce_pkg::CH_A + 8'(d - 10);
    endfunction

    // Predicts the characters that one format byte produces; returns their count
    function automatic int expand_byte(input logic [7:0] ch, input logic [15:0] val);
        logic [7:0]  chars[$];
        int unsigned rem;
        int unsigned place;
        t_chr        item;
        chars = {};
        if (ch == fpce_pkg::CH_NUL) begin
            spec_armed = 1'b0;
        end else if (spec_armed) begin
            spec_armed = 1'b0;
            if (ch == fpce_pkg::CH_LC_X || ch == fpce_pkg::CH_UC_X) begin
                for (int k = 3; k >= 0; k--) chars.push_back(ascii_digit(val[k*4 +: 4]));
            end else if (ch == fpce_pkg::CH_LC_D || ch == fpce_pkg::CH_LC_I) begin
                rem   = val;
                place = 10000;
                while (place != 0) begin
                    chars.push_back(ascii_digit(rem / place));
                    rem   = rem % place;
                    place = place / 10;
                end
            end else if (ch == fpce_pkg::CH_LC_C || ch == fpce_pkg::CH_UC_C) begin
                chars.push_back(val[7:0]);
            end
        end else if (ch == fpce_pkg::CH_PERCENT) begin
            spec_armed = 1'b1;
        end else begin
            chars.push_back(ch);
        end
        foreach (chars[k]) begin
            item.ch   = chars[k];
            item.last = (k == chars.size() - 1);
            expected_chars.push_back(item);
        end
        return chars.size();
    endfunction

    // Sends one byte, with an optional idle burst before it
    task automatic send_byte(input logic [7:0] ch, input logic [15:0] val);
        int unsigned gap;
        @(negedge i_clk);
        if (!calm_tail && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 9);
            fmt_if.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        fmt_if.valid       = 1'b1;
        fmt_if.format_char = ch;
        fmt_if.value       = val;
        do @(posedge i_clk); while (!fmt_if.ready);
        void'(expand_byte(ch, val));
        sent_items++;
    endtask

    // Receiver side: random stall bursts unless in the calm tail
    initial begin
        int unsigned stall;
        chr_if.ready = 1'b1;
        forever begin
            @(negedge i_clk);
            if (!calm_tail && $urandom_range(0, 5) == 0) begin
                stall = $urandom_range(1, 9);
                chr_if.ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            chr_if.ready = 1'b1;
        end
    end

    // Compare each character transfer with the oldest prediction
    always @(posedge i_clk) begin
        t_chr want;
        if (i_rst_n && chr_if.valid && chr_if.ready) begin
            if (expected_chars.size() == 0) begin
                report_mismatch($sformatf("unexpected char %02h last %0b",
                                          chr_if.out_char, chr_if.last));
            end else begin
                want = expected_chars.pop_front();
                if (chr_if.out_char !== want.ch)
                    report_mismatch($sformatf("out_char %02h, want %02h",
                                              chr_if.out_char, want.ch));
                if (chr_if.last !== want.last)
                    report_mismatch($sformatf("last %0b, want %0b on char %02h",
                                              chr_if.last, want.last, want.ch));
            end
        end
    end

    function automatic logic [15:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] pick_plain();
        logic [7:0] c;
        do c = 8'($urandom_range(1, 255)); while (c == fpce_pkg::CH_PERCENT);
        return c;
    endfunction

    // Field extremes, every conversion and the special cases
    task automatic test_directed();
        send_byte(8'h01, 16'h0000);
        send_byte(8'hFF, 16'hFFFF);
        send_byte(8'h7F, 16'h5A5A);
        send_byte(fpce_pkg::CH_PERCENT, 16'h0000);
        send_byte(fpce_pkg::CH_LC_X, 16'h0000);
        send_byte(fpce_pkg::CH_PERCENT, 16'h0000);
        send_byte(fpce_pkg::CH_UC_X, 16'hFFFF);
        send_byte(fpce_pkg::CH_PERCENT, 16'h0000);
        send_byte(fpce_pkg::CH_LC_D, 16'hFFFF);
        send_byte(fpce_pkg::CH_PERCENT, 16'h0000);
        send_byte(fpce_pkg::CH_LC_I, 16'h0000);
        send_byte(fpce_pkg::CH_PERCENT, 16'hFFFF);
        send_byte(fpce_pkg::CH_LC_C, 16'hFF00);      // zero low byte still comes out
        send_byte(fpce_pkg::CH_PERCENT, 16'h0000);
        send_byte(fpce_pkg::CH_UC_C, 16'h12FF);
        send_byte(fpce_pkg::CH_PERCENT, 16'h0000);
        send_byte(8'h71, 16'h1234);                  // unknown specifier
        send_byte(fpce_pkg::CH_PERCENT, 16'h0000);
        send_byte(fpce_pkg::CH_PERCENT, 16'h0000);   // second percent clears the flag
        send_byte(fpce_pkg::CH_LC_X, 16'hABCD);      // now a plain byte
        send_byte(fpce_pkg::CH_PERCENT, 16'h0000);
        send_byte(fpce_pkg::CH_NUL, 16'h3039);       // terminator while pending
        send_byte(fpce_pkg::CH_LC_D, 16'd12345);     // plain again
        send_byte(fpce_pkg::CH_NUL, 16'hFFFF);       // terminator when idle
    endtask

    // Mostly well-formed strings with random content, some noise
    task automatic test_random_strings(input int unsigned target);
        int unsigned goal;
        int unsigned kind;
        goal = sent_items + target;
        while (sent_items < goal) begin
            kind = $urandom_range(0, 99);
            if (kind < 40) begin
                send_byte(pick_plain(), pick_value());
            end else if (kind < 80) begin
                send_byte(fpce_pkg::CH_PERCENT, pick_value());
                send_byte(conv_letters[$urandom_range(0, 5)], pick_value());
            end else if (kind < 86) begin
                send_byte(fpce_pkg::CH_NUL, pick_value());
            end else if (kind < 93) begin
                send_byte(fpce_pkg::CH_PERCENT, pick_value());
                send_byte(8'($urandom_range(0, 255)), pick_value());
            end else begin
                send_byte(8'($urandom_range(0, 255)), pick_value());
            end
        end
    endtask

    initial begin
        i_rst_n            = 1'b0;
        fmt_if.valid       = 1'b0;
        fmt_if.format_char = '0;
        fmt_if.value       = '0;
        spec_armed         = 1'b0;
        calm_tail          = 1'b0;
        mismatch_count     = 0;
        cycle_count        = 0;
        sent_items         = 0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_random_strings(RANDOM_ITEMS);
        calm_tail = 1'b1;
        test_random_strings(TAIL_ITEMS);

        // Drain and let any stray output show up
        @(negedge i_clk);
        fmt_if.valid = 1'b0;
        while (expected_chars.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/fpce_pkg.sv
hw/rtl/fpce_if.sv
hw/rtl/format_print_char_expander.sv
tb/tb_format_print_char_expander.sv
